// ----- rtl/ecu_pkg.sv -----
// shared constants, codes and helpers for the euler camera update block
package ecu_pkg;

	localparam int VEC_FRAC_BITS   = 14;
	localparam int TRIG_ITERATIONS = 16;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SENS  = 1'd1;

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_TURN = 1'b1;

	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_BACKWARD = 2'd1;
	localparam logic [1:0] DIR_LEFT     = 2'd2;
	localparam logic [1:0] DIR_RIGHT    = 2'd3;

	localparam logic [15:0] MOVE_SPEED_RST = 16'd640;
	localparam logic [15:0] TURN_SENS_RST  = 16'd6554;

	// operand and product widths of the shared multiplier
	localparam int MW = 34;
	localparam int PW = 2 * MW;
	// angle accumulator width
	localparam int AW = 34;
	// cordic angle width (q11.24 degrees)
	localparam int ZW = 35;

	localparam logic signed [AW-1:0] ANG_HALF  = AW'(180 * 65536);
	localparam logic signed [AW-1:0] ANG_FULL  = AW'(360 * 65536);
	localparam logic signed [AW-1:0] PITCH_LIM = AW'(89 * 65536);

	localparam logic signed [31:0] POS_Z_RST = 32'sd196608;
	localparam logic signed [31:0] YAW_RST   = -32'sd5898240;

	localparam logic signed [ZW-1:0] Q24_NINETY = ZW'(64'd1509949440);
	localparam logic signed [MW-1:0] CORDIC_GAIN = MW'(64'd652032874);
	localparam longint RAD_Q24 = 64'd961263669;

	// arctangent of 2^-i in q11.24 degrees
	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
		longint r;
		begin
			r = 0;
			case (i)
				5'd0:  r = 754974720;
				5'd1:  r = 445687602;
				5'd2:  r = 235489089;
				5'd3:  r = 119537938;
				5'd4:  r = 60000934;
				5'd5:  r = 30029717;
				5'd6:  r = 15018523;
				5'd7:  r = 7509720;
				5'd8:  r = 3754917;
				5'd9:  r = 1877466;
				5'd10: r = 938734;
				5'd11: r = 469367;
				default: r = (RAD_Q24 + (64'sd1 << (i - 5'd1))) >>> i;
			endcase
			atan_entry = ZW'(r);
		end
	endfunction

endpackage

// ----- rtl/ecu_cmd_if.sv -----
// command and result channel interfaces
interface ecu_cmd_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [1:0]         move_dir;
	logic [15:0]        delta_time;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic               limit_pitch;

	modport source (output valid, command, move_dir, delta_time, offset_x, offset_y,
		limit_pitch, input ready);
	modport sink (input valid, command, move_dir, delta_time, offset_x, offset_y,
		limit_pitch, output ready);
endinterface

interface ecu_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] front_x;
	logic signed [15:0] front_y;
	logic signed [15:0] front_z;
	logic signed [15:0] up_x;
	logic signed [15:0] up_y;
	logic signed [15:0] up_z;

	modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		up_x, up_y, up_z, output ready);
endinterface

// ----- rtl/ecu_cordic.sv -----
// iterative cordic sine and cosine of an angle in degrees
module ecu_cordic #(
	parameter int ITERATIONS = ecu_pkg::TRIG_ITERATIONS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [31:0]            angle,
	output logic                          done,
	output logic signed [ecu_pkg::MW-1:0] cos_val,
	output logic signed [ecu_pkg::MW-1:0] sin_val
);

	localparam int IW = $clog2(ITERATIONS);

	logic signed [ecu_pkg::MW-1:0] x_q, y_q, dx, dy;
	logic signed [ecu_pkg::ZW-1:0] z_q, z0, z_in, at;
	logic                          neg_q, neg_in, run_q;
	logic [IW-1:0]                 i_q;

	always_comb begin
		z0 = ecu_pkg::ZW'(angle) <<< 8;
		z_in = z0;
		neg_in = 1'b0;
		if (z0 > ecu_pkg::Q24_NINETY) begin
			z_in = z0 - (ecu_pkg::Q24_NINETY <<< 1);
			neg_in = 1'b1;
		end else if (z0 < -ecu_pkg::Q24_NINETY) begin
			z_in = z0 + (ecu_pkg::Q24_NINETY <<< 1);
			neg_in = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = ecu_pkg::atan_entry(5'(i_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			i_q   <= '0;
			neg_q <= 1'b0;
			x_q   <= '0;
			y_q   <= '0;
			z_q   <= '0;
		end else begin
			done <= run_q && !start && (i_q == IW'(ITERATIONS - 1));
			if (start) begin
				x_q   <= ecu_pkg::CORDIC_GAIN;
				y_q   <= '0;
				z_q   <= z_in;
				neg_q <= neg_in;
				i_q   <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				if (i_q == IW'(ITERATIONS - 1)) begin
					run_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign cos_val = neg_q ? -x_q : x_q;
	assign sin_val = neg_q ? -y_q : y_q;

endmodule

// ----- rtl/euler_camera_update.sv -----
// top level of the euler camera update block
// First-person camera: a move beat steps the position along front or right by
// move_speed * delta_time, a turn beat adds scaled cursor offsets to yaw and
// pitch and rebuilds front, right and up with a cordic unit. Each beat gives one
// result beat with position, front and up. A turn repeats its wrap step until
// yaw and pitch lie in range. The two cordic passes and the shared multiplier,
// each product taken after a wait state, set how long a beat takes. One beat
// is in work at a time; the result register lets the next beat enter while a
// result waits.
module euler_camera_update #(
	parameter int VEC_FRAC_BITS   = ecu_pkg::VEC_FRAC_BITS,
	parameter int TRIG_ITERATIONS = ecu_pkg::TRIG_ITERATIONS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ecu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ecu_pkg::CFG_DAT_W-1:0] cfg_wdata,
	ecu_cmd_if.sink                       cmd,
	ecu_res_if.source                     res
);

	localparam int VW = VEC_FRAC_BITS + 2;
	localparam int MW = ecu_pkg::MW;
	localparam int PW = ecu_pkg::PW;
	localparam int AW = ecu_pkg::AW;
	localparam logic signed [PW-1:0] VONE  = PW'(1) << VEC_FRAC_BITS;
	localparam logic signed [PW-1:0] P_MAX = (PW'(1) << 31) - PW'(1);
	localparam logic signed [PW-1:0] P_MIN = -(PW'(1) << 31);
	localparam logic signed [VW-1:0] V_ONE = VW'(1) << VEC_FRAC_BITS;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WAIT, ST_MV_VEL, ST_MV_STEP, ST_TN_X, ST_TN_Y, ST_TN_WRAP,
		ST_TN_CY, ST_TN_CP, ST_FR_X, ST_FR_Z, ST_UP_ISS, ST_UP_0, ST_UP_1,
		ST_UP_2, ST_UP_3, ST_DONE
	} state_t;

	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int s);
		logic signed [PW-1:0] h;
		begin
			h = PW'(1) << (s - 1);
			rnd = (v + h) >>> s;
		end
	endfunction

	function automatic logic signed [VW-1:0] to_vec(input logic signed [PW-1:0] v,
		input int s);
		logic signed [PW-1:0] r;
		begin
			r = rnd(v, s);
			if (r > VONE)
				r = VONE;
			else if (r < -VONE)
				r = -VONE;
			to_vec = VW'(r);
		end
	endfunction

	function automatic logic signed [15:0] low16(input logic signed [VW-1:0] v);
		logic signed [31:0] w;
		begin
			w = 32'(v);
			low16 = w[15:0];
		end
	endfunction

	state_t state_q, nxt_q;
	logic [1:0] k_q;
	logic minus_q, use_right_q, lim_q;
	logic signed [15:0] offy_q;
	logic [31:0] vel_q;
	logic signed [AW-1:0] yaw_acc_q, pit_acc_q;
	logic signed [MW-1:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [PW-1:0] tmp_q, prod_q;
	logic signed [MW-1:0] mul_a_q, mul_b_q;
	logic signed [31:0] pos_q [3];
	logic signed [VW-1:0] front_q [3];
	logic signed [VW-1:0] right_q [3];
	logic signed [VW-1:0] up_q [3];
	logic signed [31:0] yaw_q, pitch_q;
	logic [15:0] speed_q, sens_q;
	logic out_valid_q;
	logic cs_start_q, cs_done;
	logic signed [31:0] cs_angle_q;
	logic signed [MW-1:0] cs_cos, cs_sin;

	logic signed [VW-1:0] vcur, vnext, rx, rz;
	logic signed [PW-1:0] step, pnew, dlt;
	logic signed [31:0] psat;
	logic yaw_ok, pit_ok;

	ecu_cordic #(
		.ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cs_start_q),
		.angle  (cs_angle_q),
		.done   (cs_done),
		.cos_val(cs_cos),
		.sin_val(cs_sin)
	);

	always_comb begin
		vcur = '0;
		vnext = '0;
		case (k_q)
			2'd0: begin
				vcur  = use_right_q ? right_q[0] : front_q[0];
				vnext = use_right_q ? right_q[1] : front_q[1];
			end
			2'd1: begin
				vcur  = use_right_q ? right_q[1] : front_q[1];
				vnext = use_right_q ? right_q[2] : front_q[2];
			end
			2'd2: begin
				vcur  = use_right_q ? right_q[2] : front_q[2];
			end
			default: begin
				vcur = '0;
			end
		endcase
		step = rnd(prod_q, 8 + VEC_FRAC_BITS);
		pnew = PW'(pos_q[k_q]) + (minus_q ? -step : step);
		if (pnew > P_MAX)
			psat = 32'(P_MAX);
		else if (pnew < P_MIN)
			psat = 32'(P_MIN);
		else
			psat = 32'(pnew);
		dlt = rnd(prod_q, 4);
		yaw_ok = (yaw_acc_q >= -ecu_pkg::ANG_HALF) && (yaw_acc_q < ecu_pkg::ANG_HALF);
		if (lim_q)
			pit_ok = (pit_acc_q >= -ecu_pkg::PITCH_LIM) && (pit_acc_q <= ecu_pkg::PITCH_LIM);
		else
			pit_ok = (pit_acc_q >= -ecu_pkg::ANG_HALF) && (pit_acc_q < ecu_pkg::ANG_HALF);
		rx = to_vec(-PW'(sy_q), 30 - VEC_FRAC_BITS);
		rz = to_vec(PW'(cy_q), 30 - VEC_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a_q) * PW'(mul_b_q);
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nxt_q       <= ST_IDLE;
			k_q         <= '0;
			minus_q     <= 1'b0;
			use_right_q <= 1'b0;
			lim_q       <= 1'b0;
			offy_q      <= '0;
			vel_q       <= '0;
			yaw_acc_q   <= '0;
			pit_acc_q   <= '0;
			cy_q        <= '0;
			sy_q        <= '0;
			cp_q        <= '0;
			sp_q        <= '0;
			tmp_q       <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			pos_q[0]    <= '0;
			pos_q[1]    <= '0;
			pos_q[2]    <= ecu_pkg::POS_Z_RST;
			front_q[0]  <= '0;
			front_q[1]  <= '0;
			front_q[2]  <= -V_ONE;
			right_q[0]  <= V_ONE;
			right_q[1]  <= '0;
			right_q[2]  <= '0;
			up_q[0]     <= '0;
			up_q[1]     <= V_ONE;
			up_q[2]     <= '0;
			yaw_q       <= ecu_pkg::YAW_RST;
			pitch_q     <= '0;
			speed_q     <= ecu_pkg::MOVE_SPEED_RST;
			sens_q      <= ecu_pkg::TURN_SENS_RST;
			out_valid_q <= 1'b0;
			cs_start_q  <= 1'b0;
			cs_angle_q  <= '0;
			res.pos_x   <= '0;
			res.pos_y   <= '0;
			res.pos_z   <= '0;
			res.front_x <= '0;
			res.front_y <= '0;
			res.front_z <= '0;
			res.up_x    <= '0;
			res.up_y    <= '0;
			res.up_z    <= '0;
		end else begin
			if (cs_start_q)
				cs_start_q <= 1'b0;
			if (cfg_wr_en) begin
				case (cfg_index)
					ecu_pkg::REG_MOVE_SPEED: speed_q <= cfg_wdata;
					ecu_pkg::REG_TURN_SENS:  sens_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid_q && res.ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (cmd.valid) begin
						state_q <= ST_WAIT;
						if (cmd.command == ecu_pkg::CMD_TURN) begin
							mul_a_q <= MW'(cmd.offset_x);
							mul_b_q <= $signed({{(MW - 16){1'b0}}, sens_q});
							offy_q  <= cmd.offset_y;
							lim_q   <= cmd.limit_pitch;
							nxt_q   <= ST_TN_X;
						end else begin
							mul_a_q     <= $signed({{(MW - 16){1'b0}}, speed_q});
							mul_b_q     <= $signed({{(MW - 16){1'b0}}, cmd.delta_time});
							use_right_q <= cmd.move_dir[1];
							minus_q     <= (cmd.move_dir == ecu_pkg::DIR_BACKWARD) ||
								(cmd.move_dir == ecu_pkg::DIR_LEFT);
							nxt_q       <= ST_MV_VEL;
						end
					end
				end
				ST_WAIT: begin
					state_q <= nxt_q;
				end
				ST_MV_VEL: begin
					vel_q   <= prod_q[31:0];
					mul_a_q <= $signed({{(MW - 32){1'b0}}, prod_q[31:0]});
					mul_b_q <= MW'(vcur);
					state_q <= ST_WAIT;
					nxt_q   <= ST_MV_STEP;
				end
				ST_MV_STEP: begin
					pos_q[k_q] <= psat;
					if (k_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						k_q     <= k_q + 2'd1;
						mul_a_q <= $signed({{(MW - 32){1'b0}}, vel_q});
						mul_b_q <= MW'(vnext);
						state_q <= ST_WAIT;
						nxt_q   <= ST_MV_STEP;
					end
				end
				ST_TN_X: begin
					yaw_acc_q <= AW'(yaw_q) + AW'(dlt);
					mul_a_q   <= MW'(offy_q);
					mul_b_q   <= $signed({{(MW - 16){1'b0}}, sens_q});
					state_q   <= ST_WAIT;
					nxt_q     <= ST_TN_Y;
				end
				ST_TN_Y: begin
					pit_acc_q <= AW'(pitch_q) + AW'(dlt);
					state_q   <= ST_TN_WRAP;
				end
				ST_TN_WRAP: begin
					if (!yaw_ok) begin
						if (yaw_acc_q < 0)
							yaw_acc_q <= yaw_acc_q + ecu_pkg::ANG_FULL;
						else
							yaw_acc_q <= yaw_acc_q - ecu_pkg::ANG_FULL;
					end
					if (!pit_ok) begin
						if (lim_q)
							pit_acc_q <= (pit_acc_q < 0) ? -ecu_pkg::PITCH_LIM :
								ecu_pkg::PITCH_LIM;
						else if (pit_acc_q < 0)
							pit_acc_q <= pit_acc_q + ecu_pkg::ANG_FULL;
						else
							pit_acc_q <= pit_acc_q - ecu_pkg::ANG_FULL;
					end
					if (yaw_ok && pit_ok) begin
						yaw_q      <= 32'(yaw_acc_q);
						pitch_q    <= 32'(pit_acc_q);
						cs_angle_q <= 32'(yaw_acc_q);
						cs_start_q <= 1'b1;
						state_q    <= ST_TN_CY;
					end
				end
				ST_TN_CY: begin
					if (cs_done) begin
						cy_q       <= cs_cos;
						sy_q       <= cs_sin;
						cs_angle_q <= pitch_q;
						cs_start_q <= 1'b1;
						state_q    <= ST_TN_CP;
					end
				end
				ST_TN_CP: begin
					if (cs_done) begin
						cp_q    <= cs_cos;
						sp_q    <= cs_sin;
						mul_a_q <= cy_q;
						mul_b_q <= cs_cos;
						state_q <= ST_WAIT;
						nxt_q   <= ST_FR_X;
					end
				end
				ST_FR_X: begin
					front_q[0] <= to_vec(prod_q, 60 - VEC_FRAC_BITS);
					mul_a_q    <= sy_q;
					mul_b_q    <= cp_q;
					state_q    <= ST_WAIT;
					nxt_q      <= ST_FR_Z;
				end
				ST_FR_Z: begin
					front_q[2] <= to_vec(prod_q, 60 - VEC_FRAC_BITS);
					front_q[1] <= to_vec(PW'(sp_q), 30 - VEC_FRAC_BITS);
					if (cp_q != 0) begin
						right_q[0] <= (cp_q < 0) ? -rx : rx;
						right_q[1] <= '0;
						right_q[2] <= (cp_q < 0) ? -rz : rz;
					end
					state_q <= ST_UP_ISS;
				end
				ST_UP_ISS: begin
					mul_a_q <= MW'(right_q[2]);
					mul_b_q <= MW'(front_q[1]);
					state_q <= ST_WAIT;
					nxt_q   <= ST_UP_0;
				end
				ST_UP_0: begin
					up_q[0] <= to_vec(-prod_q, VEC_FRAC_BITS);
					mul_a_q <= MW'(right_q[2]);
					mul_b_q <= MW'(front_q[0]);
					state_q <= ST_WAIT;
					nxt_q   <= ST_UP_1;
				end
				ST_UP_1: begin
					tmp_q   <= prod_q;
					mul_a_q <= MW'(right_q[0]);
					mul_b_q <= MW'(front_q[2]);
					state_q <= ST_WAIT;
					nxt_q   <= ST_UP_2;
				end
				ST_UP_2: begin
					up_q[1] <= to_vec(tmp_q - prod_q, VEC_FRAC_BITS);
					mul_a_q <= MW'(right_q[0]);
					mul_b_q <= MW'(front_q[1]);
					state_q <= ST_WAIT;
					nxt_q   <= ST_UP_3;
				end
				ST_UP_3: begin
					up_q[2] <= to_vec(prod_q, VEC_FRAC_BITS);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || res.ready) begin
						res.pos_x   <= pos_q[0];
						res.pos_y   <= pos_q[1];
						res.pos_z   <= pos_q[2];
						res.front_x <= low16(front_q[0]);
						res.front_y <= low16(front_q[1]);
						res.front_z <= low16(front_q[2]);
						res.up_x    <= low16(up_q[0]);
						res.up_y    <= low16(up_q[1]);
						res.up_z    <= low16(up_q[2]);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
